// ----- sv/dfre_pkg.sv -----
`timescale 1ns / 1ps
// dfre_pkg: shared types, codes and helpers of the deferred-format record encoder.
// No dependencies; imported by dfre_front, dfre_back, the top level and dfre_checker.
package dfre_pkg;

   localparam int SPEC_MAX_DEFAULT    = 16;
   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int DRAIN_W             = 7;
   localparam int CMD_DEPTH           = 2;
   localparam int RSP_DEPTH           = 2;

   localparam logic [1:0] OP_FMT = 2'd0;
   localparam logic [1:0] OP_ARG = 2'd1;
   localparam logic [1:0] OP_STR = 2'd2;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_PCT     = 8'h25;
   localparam logic [7:0] CH_STAR    = 8'h2a;
   localparam logic [7:0] CH_H       = 8'h68;
   localparam logic [7:0] CH_C       = 8'h63;
   localparam logic [7:0] CH_S       = 8'h73;
   localparam logic [7:0] CH_E_LO    = 8'h65;
   localparam logic [7:0] CH_E_UP    = 8'h45;
   localparam logic [7:0] CH_F_LO    = 8'h66;
   localparam logic [7:0] CH_F_UP    = 8'h46;
   localparam logic [7:0] CH_G_LO    = 8'h67;
   localparam logic [7:0] CH_G_UP    = 8'h47;
   localparam logic [7:0] CH_D       = 8'h64;
   localparam logic [7:0] CH_I       = 8'h69;
   localparam logic [7:0] CH_O       = 8'h6f;
   localparam logic [7:0] CH_X_LO    = 8'h78;
   localparam logic [7:0] CH_X_UP    = 8'h58;
   localparam logic [7:0] CH_U       = 8'h75;
   localparam logic [7:0] SHORT_MARK = 8'h80;

   localparam logic [2:0] INT_BYTES_WORD = 3'd4;
   localparam logic [2:0] INT_BYTES_HALF = 3'd2;
   localparam logic [2:0] INT_BYTES_ONE  = 3'd1;
   localparam logic [2:0] FLOAT_BYTES    = 3'd4;

   localparam logic [15:0] SHOWN_LEN_MAX = 16'hffff;

   typedef enum logic [2:0] {
      M_LIT,
      M_SPEC,
      M_ARG_CHAR,
      M_ARG_FLOAT,
      M_ARG_INT,
      M_ARG_STAR,
      M_STR_BARE,
      M_STR_FULL
   } mode_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_READ,
      B_DRAIN,
      B_HEAD,
      B_ARG,
      B_LEN
   } back_state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  in_char;
      logic [31:0] arg_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_length;
      logic [15:0] record_length;
      logic [1:0]  expect_next;
      logic        spec_overflow;
      logic        protocol_error;
      logic        last;
   } rsp_type;

   // one transaction's worth of work for the back end:
   // spec drain, optional head byte, argument bytes, optional length
   typedef struct packed {
      logic [DRAIN_W-1:0] drain;
      logic               has_head;
      logic [7:0]         head;
      logic [2:0]         nargs;
      logic [31:0]        arg;
      logic               has_len;
      logic               ovf;
      logic               perr;
      logic [1:0]         expect_next;
   } cmd_type;

   function automatic logic [1:0] expected_kind(input mode_type m);
      logic [1:0] k;
      if (m == M_LIT || m == M_SPEC) begin
         k = OP_FMT;
      end else if (m == M_STR_BARE || m == M_STR_FULL) begin
         k = OP_STR;
      end else begin
         k = OP_ARG;
      end
      return k;
   endfunction

   function automatic logic is_float_conv(input logic [7:0] ch);
      return ch == CH_E_LO || ch == CH_E_UP || ch == CH_F_LO || ch == CH_F_UP ||
             ch == CH_G_LO || ch == CH_G_UP;
   endfunction

   function automatic logic is_int_conv(input logic [7:0] ch);
      return ch == CH_D || ch == CH_I || ch == CH_O || ch == CH_X_LO ||
             ch == CH_X_UP || ch == CH_U;
   endfunction

endpackage

// ----- sv/dfre_ram.sv -----
`timescale 1ns / 1ps
// dfre_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/dfre_fifo.sv -----
`timescale 1ns / 1ps
// dfre_fifo: small register FIFO used for the command queue and the result queue.
// No dependencies.
module dfre_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/dfre_front.sv -----
`timescale 1ns / 1ps
// dfre_front: accepts format/argument/string transactions, tracks the format mode,
// buffers spec characters and issues commands. Depends on dfre_pkg.
module dfre_front
   import dfre_pkg::*;
#(
   parameter int SPEC_MAX = SPEC_MAX_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  req_type                     req_data,
   output logic                        cmd_push,
   output cmd_type                     cmd_data,
   input  logic                        cmd_full,
   input  logic                        drain_done,
   output logic                        spec_wr_en,
   output logic [$clog2(SPEC_MAX)-1:0] spec_wr_addr,
   output logic [7:0]                  spec_wr_data
);

   localparam int AW = $clog2(SPEC_MAX);
   localparam int CW = $clog2(SPEC_MAX + 1);

   mode_type      mode_ff, mode_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    prev_ff, prev_in;
   logic [7:0]    prev2_ff, prev2_in;
   logic [7:0]    conv_ff, conv_in;
   logic [2:0]    ib_ff, ib_in;
   logic          ovf_ff, ovf_in;
   logic          perr_ff, perr_in;
   logic          pend_ff, pend_in;
   logic          accept;
   logic          bare;
   logic [7:0]    ch;
   cmd_type       cmd;

   assign ch     = req_data.in_char;
   assign bare   = prev_ff == CH_PCT;
   // while a spec drain is outstanding the spec buffer must not be rewritten
   assign full   = cmd_full || (pend_ff && (mode_ff == M_LIT || mode_ff == M_SPEC));
   assign accept = push && !full;

   always_comb begin
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      prev_in      = prev_ff;
      prev2_in     = prev2_ff;
      conv_in      = conv_ff;
      ib_in        = ib_ff;
      ovf_in       = ovf_ff;
      perr_in      = perr_ff;
      spec_wr_en   = 1'b0;
      spec_wr_addr = cnt_ff[AW-1:0];
      spec_wr_data = ch;
      cmd          = '0;
      cmd.arg      = req_data.arg_value;
      cmd.ovf      = ovf_ff;
      cmd.perr     = perr_ff;
      if (accept) begin
         if (req_data.op != expected_kind(mode_ff)) begin
            perr_in = 1'b1;
         end else begin
            unique case (mode_ff)
               M_LIT: begin
                  if (ch == CH_NUL) begin
                     cmd.has_len = 1'b1;
                     cnt_in      = '0;
                     ovf_in      = 1'b0;
                     perr_in     = 1'b0;
                  end else if (ch == CH_PCT) begin
                     spec_wr_en   = 1'b1;
                     spec_wr_addr = '0;
                     cnt_in       = CW'(1);
                     prev2_in     = CH_NUL;
                     prev_in      = ch;
                     mode_in      = M_SPEC;
                  end else begin
                     cmd.has_head = 1'b1;
                     cmd.head     = ch;
                  end
               end
               M_SPEC: begin
                  prev2_in = prev_ff;
                  prev_in  = ch;
                  priority if (ch == CH_C || ch == CH_S) begin
                     if (!bare) begin
                        cmd.drain    = DRAIN_W'(cnt_ff);
                        cmd.has_head = 1'b1;
                        cmd.head     = ch;
                     end
                     cnt_in = '0;
                     if (ch == CH_C) begin
                        mode_in = M_ARG_CHAR;
                     end else begin
                        mode_in = bare ? M_STR_BARE : M_STR_FULL;
                     end
                  end else if (is_float_conv(ch)) begin
                     cmd.drain    = DRAIN_W'(cnt_ff);
                     cmd.has_head = 1'b1;
                     cmd.head     = ch;
                     cnt_in       = '0;
                     mode_in      = M_ARG_FLOAT;
                  end else if (is_int_conv(ch)) begin
                     if (prev_ff == CH_H) begin
                        ib_in = (prev2_ff == CH_H) ? INT_BYTES_ONE : INT_BYTES_HALF;
                     end else begin
                        ib_in = INT_BYTES_WORD;
                     end
                     conv_in   = ch;
                     cmd.drain = DRAIN_W'(cnt_ff);
                     cnt_in    = '0;
                     mode_in   = M_ARG_INT;
                  end else if (ch == CH_PCT || ch == CH_STAR) begin
                     cmd.drain    = DRAIN_W'(cnt_ff);
                     cmd.has_head = 1'b1;
                     cmd.head     = ch;
                     cnt_in       = '0;
                     mode_in      = (ch == CH_PCT) ? M_LIT : M_ARG_STAR;
                  end else if (ch == CH_NUL) begin
                     cmd.has_head = 1'b1;
                     cmd.head     = CH_NUL;
                     cmd.has_len  = 1'b1;
                     cnt_in       = '0;
                     ovf_in       = 1'b0;
                     perr_in      = 1'b0;
                     mode_in      = M_LIT;
                  end else begin
                     if (cnt_ff < CW'(SPEC_MAX)) begin
                        spec_wr_en = 1'b1;
                        cnt_in     = cnt_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
               end
               M_ARG_CHAR, M_ARG_STAR: begin
                  cmd.has_head = 1'b1;
                  cmd.head     = req_data.arg_value[7:0];
                  mode_in      = (mode_ff == M_ARG_STAR) ? M_SPEC : M_LIT;
               end
               M_ARG_FLOAT: begin
                  cmd.nargs = FLOAT_BYTES;
                  mode_in   = M_LIT;
               end
               M_ARG_INT: begin
                  cmd.has_head = 1'b1;
                  if (req_data.arg_value[31:8] == '0) begin
                     cmd.head  = conv_ff + SHORT_MARK;
                     cmd.nargs = INT_BYTES_ONE;
                  end else begin
                     cmd.head  = conv_ff;
                     cmd.nargs = ib_ff;
                  end
                  mode_in = M_LIT;
               end
               M_STR_BARE, M_STR_FULL: begin
                  if (ch != CH_NUL) begin
                     cmd.has_head = 1'b1;
                     cmd.head     = ch;
                  end else begin
                     cmd.has_head = mode_ff == M_STR_FULL;
                     cmd.head     = CH_NUL;
                     mode_in      = M_LIT;
                  end
               end
            endcase
         end
      end
      cmd.expect_next = expected_kind(mode_in);
   end

   assign cmd_data = cmd;
   assign cmd_push = accept &&
                     (cmd.drain != '0 || cmd.has_head || cmd.nargs != '0 || cmd.has_len);

   always_comb begin
      pend_in = pend_ff;
      if (drain_done) begin
         pend_in = 1'b0;
      end
      if (cmd_push && cmd.drain != '0) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_LIT;
         cnt_ff   <= '0;
         prev_ff  <= CH_NUL;
         prev2_ff <= CH_NUL;
         conv_ff  <= CH_NUL;
         ib_ff    <= INT_BYTES_WORD;
         ovf_ff   <= 1'b0;
         perr_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
         conv_ff  <= conv_in;
         ib_ff    <= ib_in;
         ovf_ff   <= ovf_in;
         perr_ff  <= perr_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ----- sv/dfre_back.sv -----
`timescale 1ns / 1ps
// dfre_back: executes queued commands, drains the spec buffer, serializes argument
// bytes and keeps the record byte count. Depends on dfre_pkg.
module dfre_back
   import dfre_pkg::*;
#(
   parameter int SPEC_MAX    = SPEC_MAX_DEFAULT,
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_empty,
   output logic                        cmd_pop,
   input  cmd_type                     cmd_data,
   output logic                        rd_en,
   output logic [$clog2(SPEC_MAX)-1:0] rd_addr,
   input  logic [7:0]                  rd_data,
   output logic                        rsp_push,
   output rsp_type                     rsp_data,
   input  logic                        rsp_full,
   output logic                        drain_done
);

   localparam int AW = $clog2(SPEC_MAX);
   localparam int CW = $clog2(SPEC_MAX + 1);

   back_state_type         state_ff, state_in;
   cmd_type                cur_ff, cur_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [1:0]             argi_ff, argi_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [LENGTH_BITS-1:0] count_inc;
   logic                   drain_last;
   logic                   arg_last;
   back_state_type         after_head;
   back_state_type         after_drain;
   back_state_type         first_state;

   function automatic logic [15:0] shown_len(input logic [LENGTH_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'(SHOWN_LEN_MAX)) ? SHOWN_LEN_MAX : w[15:0];
   endfunction

   assign count_inc  = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign drain_last = idx_ff == cur_ff.drain[CW-1:0] - 1'b1;
   assign arg_last   = 3'(argi_ff) + 3'd1 == cur_ff.nargs;
   assign after_head = (cur_ff.nargs != '0) ? B_ARG : (cur_ff.has_len ? B_LEN : B_IDLE);
   assign after_drain = cur_ff.has_head ? B_HEAD : after_head;

   always_comb begin
      if (cmd_data.drain != '0) begin
         first_state = B_READ;
      end else if (cmd_data.has_head) begin
         first_state = B_HEAD;
      end else if (cmd_data.nargs != '0) begin
         first_state = B_ARG;
      end else begin
         first_state = B_LEN;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               state_in = first_state;
            end
         end
         B_READ: begin
            state_in = B_DRAIN;
         end
         B_DRAIN: begin
            if (!rsp_full) begin
               state_in = drain_last ? after_drain : B_READ;
            end
         end
         B_HEAD: begin
            if (!rsp_full) begin
               state_in = after_head;
            end
         end
         B_ARG: begin
            if (!rsp_full && arg_last) begin
               state_in = cur_ff.has_len ? B_LEN : B_IDLE;
            end
         end
         B_LEN: begin
            if (!rsp_full) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop                 = 1'b0;
      rd_en                   = 1'b0;
      rd_addr                 = idx_ff[AW-1:0];
      rsp_push                = 1'b0;
      drain_done              = 1'b0;
      cur_in                  = cur_ff;
      idx_in                  = idx_ff;
      argi_in                 = argi_ff;
      count_in                = count_ff;
      rsp_data.out_byte       = CH_NUL;
      rsp_data.is_length      = 1'b0;
      rsp_data.record_length  = shown_len(count_inc);
      rsp_data.expect_next    = cur_ff.expect_next;
      rsp_data.spec_overflow  = cur_ff.ovf;
      rsp_data.protocol_error = cur_ff.perr;
      rsp_data.last           = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            cmd_pop = !cmd_empty;
            cur_in  = cmd_data;
            idx_in  = '0;
            argi_in = '0;
         end
         B_READ: begin
            rd_en = 1'b1;
         end
         B_DRAIN: begin
            rsp_push          = !rsp_full;
            rsp_data.out_byte = rd_data;
            rsp_data.last     = drain_last && !cur_ff.has_head && cur_ff.nargs == '0 &&
                                !cur_ff.has_len;
            if (!rsp_full) begin
               count_in   = count_inc;
               idx_in     = drain_last ? '0 : idx_ff + 1'b1;
               drain_done = drain_last;
            end
         end
         B_HEAD: begin
            rsp_push          = !rsp_full;
            rsp_data.out_byte = cur_ff.head;
            rsp_data.last     = cur_ff.nargs == '0 && !cur_ff.has_len;
            if (!rsp_full) begin
               count_in = count_inc;
            end
         end
         B_ARG: begin
            rsp_push          = !rsp_full;
            rsp_data.out_byte = cur_ff.arg[argi_ff*8 +: 8];
            rsp_data.last     = arg_last && !cur_ff.has_len;
            if (!rsp_full) begin
               count_in = count_inc;
               argi_in  = argi_ff + 1'b1;
            end
         end
         B_LEN: begin
            rsp_push               = !rsp_full;
            rsp_data.is_length     = 1'b1;
            rsp_data.record_length = shown_len(count_ff);
            rsp_data.last          = 1'b1;
            if (!rsp_full) begin
               count_in = '0;
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         idx_ff   <= '0;
         argi_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         argi_ff  <= argi_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ----- sv/deferred_format_record_encoder.sv -----
`timescale 1ns / 1ps
// Deferred-format record encoder, top level: front end, spec buffer RAM, command
// queue, back end and result queue. Depends on dfre_pkg, dfre_front, dfre_ram,
// dfre_fifo and dfre_back. A literal result passes the command queue, back end and
// result queue. The back end takes an idle state per command and one state per result
// (a read and a drain state per spec byte, bound by the registered spec RAM read).
// Reset: synchronous, active high; clears mode, counters, flags and both queues.
module deferred_format_record_encoder
   import dfre_pkg::*;
#(
   parameter int SPEC_MAX    = SPEC_MAX_DEFAULT,
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(SPEC_MAX);

   logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type       cmd_in_data, cmd_out_data;
   logic          drain_done;
   logic          spec_wr_en, spec_rd_en;
   logic [AW-1:0] spec_wr_addr, spec_rd_addr;
   logic [7:0]    spec_wr_data, spec_rd_data;
   logic          rsp_push, rsp_full;
   rsp_type       rsp_in_data;

   dfre_front #(
      .SPEC_MAX(SPEC_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in_data),
      .cmd_full    (cmd_full),
      .drain_done  (drain_done),
      .spec_wr_en  (spec_wr_en),
      .spec_wr_addr(spec_wr_addr),
      .spec_wr_data(spec_wr_data)
   );

   dfre_ram #(
      .WIDTH(8),
      .DEPTH(SPEC_MAX)
   ) u_spec_ram (
      .clock  (clock),
      .wr_en  (spec_wr_en),
      .wr_addr(spec_wr_addr),
      .wr_data(spec_wr_data),
      .rd_en  (spec_rd_en),
      .rd_addr(spec_rd_addr),
      .rd_data(spec_rd_data)
   );

   dfre_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_in_data),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .pop_data (cmd_out_data),
      .empty    (cmd_empty)
   );

   dfre_back #(
      .SPEC_MAX   (SPEC_MAX),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_out_data),
      .rd_en     (spec_rd_en),
      .rd_addr   (spec_rd_addr),
      .rd_data   (spec_rd_data),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in_data),
      .rsp_full  (rsp_full),
      .drain_done(drain_done)
   );

   dfre_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_data(rsp_in_data),
      .full     (rsp_full),
      .pop      (pop),
      .pop_data (rsp_data),
      .empty    (empty)
   );

endmodule

// ----- sv/dfre_checker.sv -----
`timescale 1ns / 1ps
// dfre_checker: port-level assertions for the deferred-format record encoder,
// bound to the top level. Depends on dfre_pkg.
module dfre_checker
   import dfre_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   a_length_shape: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.is_length |-> rsp_data.out_byte == CH_NUL && rsp_data.last)
      else $error("length transaction malformed");

   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      !empty && pop && rsp_data.is_length |=> empty || rsp_data.record_length <= 16'd1)
      else $error("byte count did not restart after length");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind deferred_format_record_encoder dfre_checker u_dfre_checker (
   .clock   (clock),
   .reset   (reset),
   .full    (full),
   .empty   (empty),
   .pop     (pop),
   .rsp_data(rsp_data)
);
